### rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Types and constants shared by the RMC sentence parser modules.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_LENGTH   = 2'd2;
    localparam logic [1:0] ST_NOFIX    = 2'd3;

    localparam logic [1:0] REG_ZONE    = 2'd0;
    localparam logic [1:0] REG_MIN_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_sentence;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [6:0]  lat_degrees;
        logic [19:0] lat_minutes;
        logic [9:0]  lon_degrees;
        logic [19:0] lon_minutes;
        logic [1:0]  hemispheres;
    } out_item_t;

    // Classified byte handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_sentence;
        logic       is_comma;
        logic [3:0] digit;
        logic [4:0] hex;
    } cls_item_t;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
        return r;
    endfunction

endpackage

### rtl/nrmc_if.sv
// ----------------------------------------------------------------------------
// nrmc_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface nrmc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/nrmc_cfg_if.sv
// ----------------------------------------------------------------------------
// nrmc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface nrmc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/nrmc_front.sv
// ----------------------------------------------------------------------------
// nrmc_front
// Accepts bytes, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module nrmc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    nrmc_if.sink                 in_ch,
    input  logic                 pop,
    output logic                 q_valid,
    output nrmc_pkg::cls_item_t  q_data
);

    nrmc_pkg::cls_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    nrmc_pkg::cls_item_t cls;

    always_comb
    begin
        cls.char_in         = in_ch.data.char_in;
        cls.end_of_sentence = in_ch.data.end_of_sentence;
        cls.is_comma        = (in_ch.data.char_in == nrmc_pkg::CH_COMMA);
        cls.hex             = nrmc_pkg::hex_of(in_ch.data.char_in);
        cls.digit           = (in_ch.data.char_in >= 8'h30 && in_ch.data.char_in <= 8'h39)
                              ? cls.hex[3:0] : 4'd0;
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_data      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

endmodule

### rtl/nrmc_back.sv
// ----------------------------------------------------------------------------
// nrmc_back
// Field decoder: updates sentence state per byte and forms the result.
// ----------------------------------------------------------------------------
module nrmc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  nrmc_pkg::cls_item_t  q_data,
    output logic                 pop,
    input  logic [4:0]           zone,
    input  logic [7:0]           min_len,
    input  logic [7:0]           max_len,
    nrmc_if.source               out_ch
);

    logic [7:0]  x0_reg, x1_reg, x2_reg, last_reg;
    logic [7:0]  cnt_reg;
    logic [3:0]  fld_reg, pos_reg;
    logic [4:0]  h_reg;
    logic [5:0]  m_reg, s_reg;
    logic        fix_reg;
    logic [19:0] acc_reg [4];
    logic [1:0]  hem_reg;
    logic [6:0]  dt_reg [3];
    logic        ov_reg;
    nrmc_pkg::out_item_t od_reg;

    logic [7:0]  cnt_sat;
    logic [3:0]  d;
    logic [4:0]  hi, lo;
    logic [1:0]  st;
    logic [5:0]  hsum;
    logic [4:0]  hloc;
    logic [19:0] w0, w1, w2, w3;
    logic [6:0]  d10;
    nrmc_pkg::out_item_t res;

    assign pop = q_valid && (!ov_reg || out_ch.ready);
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;
    assign d       = q_data.digit;
    assign d10     = 7'(d) * 7'd10;
    assign cnt_sat = (cnt_reg == 8'hFF) ? cnt_reg : 8'(cnt_reg + 8'd1);
    assign hi      = nrmc_pkg::hex_of(last_reg);
    assign lo      = q_data.hex;
    assign hsum    = 6'(h_reg) + 6'(zone);
    assign hloc    = (hsum >= 6'd48) ? 5'(hsum - 6'd48)
                   : (hsum >= 6'd24) ? 5'(hsum - 6'd24) : hsum[4:0];

    always_comb
    begin
        w0 = 20'd0; w1 = 20'd0; w2 = 20'd0; w3 = 20'd0;
        case (pos_reg)
            4'd0: begin w0 = 20'd10; w2 = 20'd100; end
            4'd1: begin w0 = 20'd1;  w2 = 20'd10; end
            4'd2: begin w1 = 20'd100000; w2 = 20'd1; end
            4'd3: begin w1 = 20'd10000; w3 = 20'd100000; end
            4'd4: w3 = 20'd10000;
            4'd5: w1 = 20'd1000;
            4'd6: begin w1 = 20'd100; w3 = 20'd1000; end
            4'd7: begin w1 = 20'd10; w3 = 20'd100; end
            4'd8: begin w1 = 20'd1; w3 = 20'd10; end
            4'd9: w3 = 20'd1;
            default: ;
        endcase
    end

    always_comb
    begin
        if (hi[4] || lo[4] || {hi[3:0], lo[3:0]} != x2_reg) st = nrmc_pkg::ST_CHECKSUM;
        else if (cnt_sat < min_len || cnt_sat > max_len) st = nrmc_pkg::ST_LENGTH;
        else if (!fix_reg) st = nrmc_pkg::ST_NOFIX;
        else st = nrmc_pkg::ST_OK;
        res = '0;
        res.status = st;
        if (st == nrmc_pkg::ST_OK)
        begin
            res.hour        = hloc;
            res.minute      = m_reg;
            res.second      = s_reg;
            res.day         = (dt_reg[0] > 7'd31) ? 5'd31 : dt_reg[0][4:0];
            res.month       = (dt_reg[1] > 7'd15) ? 4'd15 : dt_reg[1][3:0];
            res.year        = dt_reg[2];
            res.lat_degrees = acc_reg[0][6:0];
            res.lat_minutes = acc_reg[1];
            res.lon_degrees = acc_reg[2][9:0];
            res.lon_minutes = acc_reg[3];
            res.hemispheres = hem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_data.end_of_sentence)
        begin
            od_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            x0_reg <= '0; x1_reg <= '0; x2_reg <= '0; last_reg <= '0;
            cnt_reg <= '0; fld_reg <= '0; pos_reg <= '0;
            h_reg <= '0; m_reg <= '0; s_reg <= '0; fix_reg <= 1'b0; hem_reg <= '0;
            for (int i = 0; i < 4; i++) acc_reg[i] <= '0;
            for (int i = 0; i < 3; i++) dt_reg[i] <= '0;
        end
        else
        begin
            ov_reg <= (pop && q_data.end_of_sentence) || (ov_reg && !out_ch.ready);
            if (pop && q_data.end_of_sentence)
            begin
                x0_reg <= '0; x1_reg <= '0; x2_reg <= '0; last_reg <= '0;
                cnt_reg <= '0; fld_reg <= '0; pos_reg <= '0;
                h_reg <= '0; m_reg <= '0; s_reg <= '0; fix_reg <= 1'b0; hem_reg <= '0;
                for (int i = 0; i < 4; i++) acc_reg[i] <= '0;
                for (int i = 0; i < 3; i++) dt_reg[i] <= '0;
            end
            else if (pop)
            begin
                cnt_reg  <= cnt_sat;
                x2_reg   <= x1_reg;
                x1_reg   <= x0_reg;
                x0_reg   <= x0_reg ^ q_data.char_in;
                last_reg <= q_data.char_in;
                if (q_data.is_comma)
                begin
                    if (fld_reg != 4'd15) fld_reg <= 4'(fld_reg + 4'd1);
                    pos_reg <= '0;
                end
                else
                begin
                    if (pos_reg != 4'd15) pos_reg <= 4'(pos_reg + 4'd1);
                    case (fld_reg)
                        4'd1:
                        begin
                            case (pos_reg)
                                // Ten times the tens digit, reduced modulo 24.
                                4'd0: h_reg <= (d10 >= 7'd72) ? 5'(d10 - 7'd72)
                                             : (d10 >= 7'd48) ? 5'(d10 - 7'd48)
                                             : (d10 >= 7'd24) ? 5'(d10 - 7'd24) : d10[4:0];
                                4'd1: h_reg <= ((6'(h_reg) + 6'(d)) >= 6'd24)
                                             ? 5'(6'(h_reg) + 6'(d) - 6'd24)
                                             : 5'(h_reg + 5'(d));
                                4'd2: m_reg <= (d10 > 7'd63) ? 6'd63 : d10[5:0];
                                4'd3: m_reg <= ((7'(m_reg) + 7'(d)) > 7'd63) ? 6'd63
                                             : 6'(m_reg + 6'(d));
                                4'd4: s_reg <= (d10 > 7'd63) ? 6'd63 : d10[5:0];
                                4'd5: s_reg <= ((7'(s_reg) + 7'(d)) > 7'd63) ? 6'd63
                                             : 6'(s_reg + 6'(d));
                                default: ;
                            endcase
                        end
                        4'd2: if (pos_reg == 4'd0) fix_reg <= (q_data.char_in == nrmc_pkg::CH_A);
                        4'd3:
                        begin
                            acc_reg[0] <= 20'(acc_reg[0] + w0 * 20'(d));
                            acc_reg[1] <= 20'(acc_reg[1] + w1 * 20'(d));
                        end
                        4'd4: if (pos_reg == 4'd0 && q_data.char_in == nrmc_pkg::CH_S)
                                  hem_reg[0] <= 1'b1;
                        4'd5:
                        begin
                            acc_reg[2] <= 20'(acc_reg[2] + w2 * 20'(d));
                            acc_reg[3] <= 20'(acc_reg[3] + w3 * 20'(d));
                        end
                        4'd6: if (pos_reg == 4'd0 && q_data.char_in == nrmc_pkg::CH_W)
                                  hem_reg[1] <= 1'b1;
                        4'd9:
                        begin
                            if (pos_reg < 4'd6)
                            begin
                                if (!pos_reg[0]) dt_reg[pos_reg[2:1]] <= d10;
                                else dt_reg[pos_reg[2:1]] <= 7'(dt_reg[pos_reg[2:1]] + 7'(d));
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

endmodule

### rtl/nmea_rmc_sentence_parser_unit.sv
// A result is registered in the back end once its last byte, held first in the
// front-end queue, is popped. The unit takes one byte per cycle while no result
// waits for the sink; the back end decodes each byte as it is popped, and a
// two-entry queue decouples it from the input. While a result waits for the
// sink the back end stalls, and the queue fills its two entries before the input stalls.
// Reset clears all sentence state; registers return to 8, 60 and 80.
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit
// RMC sentence parser top level: configuration registers, front and back.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit
(
    input  logic     clk,
    input  logic     rst_n,
    nrmc_cfg_if.sink cfg,
    nrmc_if.sink     in_ch,
    nrmc_if.source   out_ch
);

    logic [4:0] zone_reg;
    logic [7:0] min_reg, max_reg;
    logic       q_valid, pop;
    nrmc_pkg::cls_item_t q_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= 5'd8;
            min_reg  <= 8'd60;
            max_reg  <= 8'd80;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                nrmc_pkg::REG_ZONE:    zone_reg <= cfg.data[4:0];
                nrmc_pkg::REG_MIN_LEN: min_reg  <= cfg.data;
                nrmc_pkg::REG_MAX_LEN: max_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    nrmc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .pop     (pop),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    nrmc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .zone    (zone_reg),
        .min_len (min_reg),
        .max_len (max_reg),
        .out_ch  (out_ch)
    );

endmodule

### tb/sv/nmea_rmc_sentence_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_unit_tb
// Feeds RMC sentences, well-formed, corrupted and random, one byte per
// transaction. A behavioral parser predicts each result, and a monitor
// compares the results field by field in order of arrival.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    nrmc_cfg_if                         cfg ();
    nrmc_if #(.T(nrmc_pkg::in_item_t))  in_ch ();
    nrmc_if #(.T(nrmc_pkg::out_item_t)) out_ch ();

    nmea_rmc_sentence_parser_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Parser state for prediction.
    logic [4:0]  zone_hours;
    logic [7:0]  len_min;
    logic [7:0]  len_max;
    logic [7:0]  run_xor [3];
    logic [7:0]  prev_byte;
    logic [7:0]  nbytes;
    logic [3:0]  field_idx;
    logic [3:0]  char_pos;
    logic [4:0]  t_hour;
    logic [5:0]  t_min;
    logic [5:0]  t_sec;
    logic        fix_ok;
    int unsigned lat_deg, lat_min, lon_deg, lon_min;
    logic [1:0]  hemi;
    int unsigned date_val [3];

    nrmc_pkg::in_item_t  byte_queue [$];
    nrmc_pkg::out_item_t expected_results [$];
    int        errors;
    bit        sender_hold;
    bit        long_hold_req;
    int        idle_cycles;

    function automatic int unsigned digit_val(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) ? int'(c - nrmc_pkg::CH_ZERO) : 0;
    endfunction

    function automatic int unsigned hex_val(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        return 16;
    endfunction

    function automatic int unsigned sat(int unsigned v, int unsigned lim);
        return v > lim ? lim : v;
    endfunction

    task automatic clear_sentence();
        run_xor = '{8'h00, 8'h00, 8'h00};
        prev_byte = 8'h00;
        nbytes = 8'h00;
        field_idx = 4'd0;
        char_pos = 4'd0;
        t_hour = 5'd0;
        t_min = 6'd0;
        t_sec = 6'd0;
        fix_ok = 1'b0;
        lat_deg = 0;
        lat_min = 0;
        lon_deg = 0;
        lon_min = 0;
        hemi = 2'b00;
        date_val = '{0, 0, 0};
    endtask

    task automatic decode_char(logic [7:0] c);
        int unsigned d;
        int unsigned p;
        int unsigned w1, w2;
        d = digit_val(c);
        p = char_pos;
        if (c == nrmc_pkg::CH_COMMA)
        begin
            if (field_idx < 15) field_idx++;
            char_pos = 4'd0;
            return;
        end
        case (field_idx)
            4'd1:
            begin
                case (p)
                    0: t_hour = 5'((d * 10) % 24);
                    1: t_hour = 5'((t_hour + d) % 24);
                    2: t_min = 6'(sat(d * 10, 63));
                    3: t_min = 6'(sat(t_min + d, 63));
                    4: t_sec = 6'(sat(d * 10, 63));
                    5: t_sec = 6'(sat(t_sec + d, 63));
                    default: ;
                endcase
            end
            4'd2: if (p == 0) fix_ok = (c == nrmc_pkg::CH_A);
            4'd3:
            begin
                w1 = p == 0 ? 10 : p == 1 ? 1 : 0;
                case (p)
                    2: w2 = 100000;
                    3: w2 = 10000;
                    5: w2 = 1000;
                    6: w2 = 100;
                    7: w2 = 10;
                    8: w2 = 1;
                    default: w2 = 0;
                endcase
                lat_deg += d * w1;
                lat_min += d * w2;
            end
            4'd4: if (p == 0 && c == nrmc_pkg::CH_S) hemi[0] = 1'b1;
            4'd5:
            begin
                w1 = p == 0 ? 100 : p == 1 ? 10 : p == 2 ? 1 : 0;
                case (p)
                    3: w2 = 100000;
                    4: w2 = 10000;
                    6: w2 = 1000;
                    7: w2 = 100;
                    8: w2 = 10;
                    9: w2 = 1;
                    default: w2 = 0;
                endcase
                lon_deg += d * w1;
                lon_min += d * w2;
            end
            4'd6: if (p == 0 && c == nrmc_pkg::CH_W) hemi[1] = 1'b1;
            4'd9:
            begin
                if (p < 6)
                begin
                    if (p % 2 == 0) date_val[p / 2] = d * 10;
                    else date_val[p / 2] = (date_val[p / 2] + d) & 32'h7F;
                end
            end
            default: ;
        endcase
        if (char_pos < 15) char_pos++;
    endtask

    task automatic parse_byte(nrmc_pkg::in_item_t b);
        int unsigned hi, lo;
        nrmc_pkg::out_item_t r;
        if (nbytes != 8'hFF) nbytes++;
        if (!b.end_of_sentence)
        begin
            run_xor[2] = run_xor[1];
            run_xor[1] = run_xor[0];
            run_xor[0] = run_xor[0] ^ b.char_in;
            prev_byte = b.char_in;
            decode_char(b.char_in);
            return;
        end
        hi = hex_val(prev_byte);
        lo = hex_val(b.char_in);
        r = '0;
        if (hi > 15 || lo > 15 || ((hi << 4) | lo) != run_xor[2])
            r.status = nrmc_pkg::ST_CHECKSUM;
        else if (nbytes < len_min || nbytes > len_max) r.status = nrmc_pkg::ST_LENGTH;
        else if (!fix_ok) r.status = nrmc_pkg::ST_NOFIX;
        else r.status = nrmc_pkg::ST_OK;
        if (r.status == nrmc_pkg::ST_OK)
        begin
            r.hour = 5'((t_hour + zone_hours) % 24);
            r.minute = t_min;
            r.second = t_sec;
            r.day = 5'(sat(date_val[0], 31));
            r.month = 4'(sat(date_val[1], 15));
            r.year = 7'(date_val[2]);
            r.lat_degrees = 7'(lat_deg);
            r.lat_minutes = 20'(lat_min);
            r.lon_degrees = 10'(lon_deg);
            r.lon_minutes = 20'(lon_min);
            r.hemispheres = hemi;
        end
        expected_results.push_back(r);
        clear_sentence();
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic string digits(int n);
        string s;
        s = "";
        repeat (n) s = {s, string'(8'(8'h30 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string hex2(logic [7:0] v);
        string s;
        s.hextoa(v);
        if (s.len() < 2) s = {"0", s};
        if ($urandom_range(0, 3) == 0) s = s.tolower();
        else s = s.toupper();
        return s;
    endfunction

    // Queue a body plus '*' and checksum; corrupt selects a bad checksum.
    task automatic queue_sentence(string body, bit corrupt);
        logic [7:0] x;
        string cs;
        nrmc_pkg::in_item_t b;
        x = 8'h00;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        if (corrupt) x ^= 8'(1 << $urandom_range(0, 7));
        cs = {"*", hex2(x)};
        body = {body, cs};
        for (int i = 0; i < body.len(); i++)
        begin
            b.char_in = body[i];
            b.end_of_sentence = (i == body.len() - 1);
            byte_queue.push_back(b);
        end
    endtask

    task automatic queue_raw(string s);
        nrmc_pkg::in_item_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.char_in = s[i];
            b.end_of_sentence = (i == s.len() - 1);
            byte_queue.push_back(b);
        end
    endtask

    function automatic string random_rmc();
        string s;
        s = {"GPRMC,", digits(6), ".", digits(2), ","};
        s = {s, ($urandom_range(0, 5) == 0) ? "V" : "A", ","};
        s = {s, digits(4), ".", digits(4), ",", $urandom_range(0, 1) ? "S" : "N", ","};
        s = {s, digits(5), ".", digits(4), ",", $urandom_range(0, 1) ? "W" : "E", ","};
        s = {s, digits(3), ".", digits(1), ",", digits(3), ".", digits(1), ","};
        s = {s, digits(6), ",,,A"};
        return s;
    endfunction

    task automatic wait_drained();
        while (byte_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            nrmc_pkg::REG_ZONE:    zone_hours = val[4:0];
            nrmc_pkg::REG_MIN_LEN: len_min = val;
            nrmc_pkg::REG_MAX_LEN: len_max = val;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e !== a)
        begin
            $error("%s expected %0d actual %0d", name, e, a);
            errors++;
        end
    endtask

    // ---------------- clock and reset ----------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- driver ----------------
    int send_wait;
    bit accepted_last;

    // Acceptance is recorded at the rising edge; the next byte goes out at the falling edge.
    always @(posedge clk)
    begin
        accepted_last <= 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            parse_byte(in_ch.data);
            void'(byte_queue.pop_front());
            accepted_last <= 1'b1;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_wait = 0;
        end
        else if (in_ch.valid && !accepted_last)
        begin
            // The offer stays up until it is taken.
        end
        else if (send_wait > 0)
        begin
            send_wait--;
            in_ch.valid <= 1'b0;
        end
        else if (byte_queue.size() != 0 && !sender_hold)
        begin
            in_ch.valid <= 1'b1;
            in_ch.data <= byte_queue[0];
            send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    int recv_wait;
    always @(posedge clk)
    begin
        nrmc_pkg::out_item_t got, exp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result status=%0d", got.status);
                errors++;
            end
            else
            begin
                exp = expected_results.pop_front();
                check_field("status", exp.status, got.status);
                check_field("hour", exp.hour, got.hour);
                check_field("minute", exp.minute, got.minute);
                check_field("second", exp.second, got.second);
                check_field("day", exp.day, got.day);
                check_field("month", exp.month, got.month);
                check_field("year", exp.year, got.year);
                check_field("lat_degrees", exp.lat_degrees, got.lat_degrees);
                check_field("lat_minutes", exp.lat_minutes, got.lat_minutes);
                check_field("lon_degrees", exp.lon_degrees, got.lon_degrees);
                check_field("lon_minutes", exp.lon_minutes, got.lon_minutes);
                check_field("hemispheres", exp.hemispheres, got.hemispheres);
            end
        end
    end

    // Ready changes at the falling edge; a long hold is counted here.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else if (long_hold_req)
        begin
            out_ch.ready <= 1'b0;
            recv_wait = 300;
            long_hold_req = 1'b0;
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) recv_wait = $urandom_range(0, 18);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        string base;
        nrmc_pkg::in_item_t b;
        errors = 0;
        idle_cycles = 0;
        sender_hold = 1'b0;
        long_hold_req = 1'b0;
        zone_hours = 5'd8;
        len_min = 8'd60;
        len_max = 8'd80;
        clear_sentence();
        cfg.valid = 1'b0;
        cfg.index = nrmc_pkg::REG_ZONE;
        cfg.data = 8'h00;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sentences at reset settings.
        base = "GPRMC,235959.00,A,9959.9999,S,17959.9999,W,000.0,360.0,311299,,,A";
        queue_sentence(base, 0);
        queue_sentence("GPRMC,000000.00,A,0000.0000,N,00000.0000,E,0.0,0.0,010100,,,A", 0);
        queue_sentence(base, 1);                              // checksum mismatch
        queue_sentence("GPRMC,123456,V,4807.0380,N,01131.0000,E,1,2,230394,,,A", 0);
        queue_sentence("GPRMC,1", 0);                         // bad length
        queue_sentence("GPRMC,99x9x9.00,A,48,N,011,E,,,995599,,,AAAAAAAAAAA", 0);
        queue_sentence("GPRMC,120000.00,,4807.0380,N,01131.0000,E,,,230394,,,AAAAAA", 0);
        queue_raw("G*GG");                                    // non-hex checksum
        queue_raw("*00");
        queue_raw("0");                                       // lone last byte
        queue_raw("*z0");
        wait_drained();

        // Extremes of the registers.
        write_reg(nrmc_pkg::REG_ZONE, 8'd23);
        write_reg(nrmc_pkg::REG_MIN_LEN, 8'd0);
        write_reg(nrmc_pkg::REG_MAX_LEN, 8'd255);
        queue_sentence(base, 0);
        queue_raw("*00");
        repeat (40) queue_raw("X");                           // single-byte sentences
        queue_sentence("GPRMC,101010,A,,,,,,,010101", 0);
        begin
            // Over-long sentence: byte count must saturate.
            string s;
            s = "GPRMC,101010,A";
            repeat (260) s = {s, "9"};
            queue_sentence(s, 0);
        end
        wait_drained();
        write_reg(nrmc_pkg::REG_ZONE, 8'd0);
        write_reg(nrmc_pkg::REG_MIN_LEN, 8'd255);
        write_reg(nrmc_pkg::REG_MAX_LEN, 8'd0);               // min above max
        queue_sentence(base, 0);
        wait_drained();

        // Pressure: long receiver hold while bytes keep flowing.
        write_reg(nrmc_pkg::REG_ZONE, 8'd8);
        write_reg(nrmc_pkg::REG_MIN_LEN, 8'd4);
        write_reg(nrmc_pkg::REG_MAX_LEN, 8'd80);
        long_hold_req = 1'b1;
        repeat (8) queue_raw("A,A*40");
        wait_drained();

        // Random phases with different settings.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(nrmc_pkg::REG_ZONE, 8'($urandom_range(0, 23)));
            write_reg(nrmc_pkg::REG_MIN_LEN, 8'($urandom_range(40, 70)));
            write_reg(nrmc_pkg::REG_MAX_LEN, 8'($urandom_range(65, 90)));
            for (int n = 0; n < 2; n++)
            begin
                int k;
                k = $urandom_range(0, 9);
                if (k < 7) queue_sentence(random_rmc(), k == 0);
                else if (k == 7)
                begin
                    repeat ($urandom_range(1, 12))
                    begin
                        b.char_in = 8'($urandom_range(0, 255));
                        b.end_of_sentence = 1'b0;
                        byte_queue.push_back(b);
                    end
                    queue_sentence("GPRMC,", 0);
                end
                else
                begin
                    b.char_in = 8'($urandom_range(0, 255));
                    b.end_of_sentence = $urandom_range(0, 1);
                    byte_queue.push_back(b);
                end
                if (phase == 2 && n == 1)
                begin
                    // Sender waits for every result before continuing.
                    sender_hold = 1'b1;
                    while (expected_results.size() != 0 ||
                           (byte_queue.size() != 0 && in_ch.valid)) @(posedge clk);
                    sender_hold = 1'b0;
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

### files.f
rtl/nrmc_pkg.sv
rtl/nrmc_if.sv
rtl/nrmc_cfg_if.sv
rtl/nrmc_front.sv
rtl/nrmc_back.sv
rtl/nmea_rmc_sentence_parser_unit.sv
tb/sv/nmea_rmc_sentence_parser_unit_tb.sv
